// File: rtl/core/kdv_pkg.sv
// Shared types and constants for the kick drum voice.
package kdv_pkg;

  // Datapath operations, one per controller step
  typedef logic [4:0] op_t;
  localparam op_t OP_NOP  = 5'd0;
  localparam op_t OP_LOAD = 5'd1;
  localparam op_t OP_SIL  = 5'd2;
  localparam op_t OP_PENV = 5'd3;
  localparam op_t OP_ESW  = 5'd4;
  localparam op_t OP_DIV3 = 5'd5;
  localparam op_t OP_EXP  = 5'd6;
  localparam op_t OP_EXPF = 5'd7;
  localparam op_t OP_INC  = 5'd8;
  localparam op_t OP_CENV = 5'd9;
  localparam op_t OP_CLK  = 5'd10;
  localparam op_t OP_NENV = 5'd11;
  localparam op_t OP_NM1  = 5'd12;
  localparam op_t OP_NM2  = 5'd13;
  localparam op_t OP_NDIV = 5'd14;
  localparam op_t OP_NADD = 5'd15;
  localparam op_t OP_MAG  = 5'd16;
  localparam op_t OP_TG   = 5'd17;
  localparam op_t OP_TGD  = 5'd18;
  localparam op_t OP_SH   = 5'd19;
  localparam op_t OP_SHD  = 5'd20;
  localparam op_t OP_DRV  = 5'd21;
  localparam op_t OP_AENV = 5'd22;
  localparam op_t OP_AMP  = 5'd23;
  localparam op_t OP_LVL  = 5'd24;

  typedef struct packed {
    op_t        op;
    logic [2:0] idx;
  } kdv_cmd_t;

  typedef struct packed {
    logic silent;
    logic drive_zero;
    logic div_done;
  } kdv_stat_t;

  // Register indexes
  localparam logic [2:0] REG_BASE_INC = 3'd0;
  localparam logic [2:0] REG_SWEEP    = 3'd1;
  localparam logic [2:0] REG_PCOEF    = 3'd2;
  localparam logic [2:0] REG_BCOEF    = 3'd3;
  localparam logic [2:0] REG_NCOEF    = 3'd4;
  localparam logic [2:0] REG_NMIX     = 3'd5;
  localparam logic [2:0] REG_DRIVE    = 3'd6;
  localparam logic [2:0] REG_CMIX     = 3'd7;

  localparam logic [19:0] RST_BASE_INC = 20'd20972;
  localparam logic [9:0]  RST_SWEEP    = 10'd576;
  localparam logic [23:0] RST_PCOEF    = 24'd16742299;
  localparam logic [23:0] RST_BCOEF    = 24'd16773721;
  localparam logic [23:0] RST_NCOEF    = 24'd16690062;
  localparam logic [16:0] RST_NMIX     = 17'd9830;
  localparam logic [16:0] RST_DRIVE    = 17'd19661;
  localparam logic [16:0] RST_CMIX     = 17'd32768;

  localparam logic [23:0] ENV_FULL      = 24'hFFFFFF;
  localparam logic [23:0] SILENCE_LEVEL = 24'd1678;
  localparam logic [24:0] Q24_ONE       = 25'h1000000;
  localparam logic [29:0] EXP_ONE       = 30'h10000000;
  localparam logic [31:0] DIV3_RECIP    = 32'hAAAAAAAB;
  localparam logic [41:0] NOISE_DIV     = 42'd32767;
  localparam logic [31:0] LEVEL_SCALE   = 32'd32767;
  localparam logic [63:0] INV_LN2_Q28   = 64'd387270501;

  // Divider geometry
  localparam int DIV_NW = 49;
  localparam int DIV_DW = 25;

  localparam logic [63:0] SIN_COEF [5] = '{64'd421657428, 64'd173399667, 64'd21392326,
                                           64'd1256749, 64'd43068};
  localparam logic [29:0] EXP_COEF [6] = '{30'd186065280, 30'd64485312, 30'd14899271,
                                           30'd2581847, 30'd357920, 30'd41348};

endpackage

// File: rtl/core/kdv_div.sv
// Restoring divider, one quotient bit per cycle.
module kdv_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [kdv_pkg::DIV_NW-1:0]  dividend,
  input  logic [kdv_pkg::DIV_DW-1:0]  divisor,
  output logic                        done,
  output logic [kdv_pkg::DIV_NW-1:0]  quotient
);
  import kdv_pkg::*;

  localparam int CW = $clog2(DIV_NW);
  localparam logic [CW-1:0] LAST = CW'(DIV_NW - 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dsr;
  logic [DIV_DW:0]   sh;
  logic              ge;

  assign sh = {rem, quo[DIV_NW-1]};
  assign ge = sh >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? DIV_DW'(sh - {1'b0, dsr}) : DIV_DW'(sh);
      quo <= {quo[DIV_NW-2:0], ge};
    end
  end

endmodule

// File: rtl/core/kdv_dp.sv
// Datapath: registers, voice state, shared multiplier, tables and divider.
module kdv_dp #(
  parameter int          PHASE_BITS         = 24,
  parameter int          SINE_TABLE_DEPTH   = 1024,
  parameter int          SHAPER_TABLE_DEPTH = 1024,
  parameter logic [23:0] CLICK_DECAY        = 24'd16204694
) (
  input  logic                    clk,
  input  logic                    rst,
  input  kdv_pkg::kdv_cmd_t       cmd,
  output kdv_pkg::kdv_stat_t      stat,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [23:0]             cfg_data,
  input  logic                    kind,
  input  logic signed [15:0]      noise_in,
  output logic signed [15:0]      audio_out,
  output logic                    sounding
);
  import kdv_pkg::*;

  localparam int SA     = $clog2(SINE_TABLE_DEPTH);
  localparam int HA     = $clog2(SHAPER_TABLE_DEPTH);
  localparam int SPW    = PHASE_BITS + SA + 1;
  localparam int HPW    = 27 + HA + 1;
  localparam int INC_SH = 52 - PHASE_BITS;

  typedef logic signed [25:0] sine_rom_t [SINE_TABLE_DEPTH];
  typedef logic [24:0] shp_rom_t [SHAPER_TABLE_DEPTH];

  // shift-subtract quotient for table building
  function automatic logic [63:0] const_div(logic [63:0] num, logic [63:0] den);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t r;
    logic [63:0] u, quad, f, x, x2, p, s;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      u = (64'(i) << 30) / SINE_TABLE_DEPTH;
      quad = (u >> 28) & 64'd3;
      f = u & 64'hFFFFFFF;
      x = quad[0] ? (64'h10000000 - f) : f;
      x2 = (x * x) >> 28;
      p = SIN_COEF[4];
      for (int j = 3; j >= 0; j--) begin
        p = SIN_COEF[j] - ((x2 * p) >> 28);
      end
      p = (x * p) >> 28;
      if (p > 64'h10000000) begin
        p = 64'h10000000;
      end
      s = p >> 4;
      r[i] = quad[1] ? -$signed(26'(s)) : $signed(26'(s));
    end
    return r;
  endfunction

  function automatic shp_rom_t build_shaper();
    shp_rom_t r;
    logic [63:0] y, z, k, f, p, e, den;
    for (int i = 0; i < SHAPER_TABLE_DEPTH; i++) begin
      y = (64'(i) << 27) / SHAPER_TABLE_DEPTH;
      z = (y * 64'd2 * INV_LN2_Q28) >> 28;
      k = (z >> 24) & 64'd31;
      f = (z & 64'hFFFFFF) << 4;
      p = 64'(EXP_COEF[5]);
      for (int j = 4; j >= 0; j--) begin
        p = 64'(EXP_COEF[j]) + ((f * p) >> 28);
      end
      e = 64'h10000000 + ((f * p) >> 28);
      den = (e << k) + 64'h10000000;
      r[i] = 25'(64'h1000000 - const_div(64'd1 << 53, den));
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM  = build_sine();
  localparam shp_rom_t  SHP_ROM   = build_shaper();

  // configuration
  logic [19:0] base_inc;
  logic [9:0]  sweep;
  logic [23:0] pcoef, bcoef, ncoef;
  logic [16:0] nmix, drive, cmix;

  // voice state
  logic [PHASE_BITS-1:0] phase;
  logic [23:0] penv, aenv, nenv, cenv;

  // working registers
  logic signed [15:0] noise_q;
  logic [30:0]        e_q;
  logic [29:0]        p_q;
  logic [41:0]        t_q;
  logic [27:0]        nq_q;
  logic signed [29:0] x_q;
  logic               neg_q;
  logic [28:0]        mag_q;
  logic [24:0]        tg_q;
  logic signed [25:0] sine_q;
  logic [24:0]        shp_q;
  logic               big_q;

  logic [33:0] mul_a;
  logic [31:0] mul_b;
  logic [65:0] prod;

  logic [56:0] inc_w;
  logic [56:0] inc_s;
  logic [SPW-1:0] sine_p;
  logic [SA-1:0]  sine_idx;
  logic [19:0]    gain;
  logic [27:0]    gm;
  logic [26:0]    sh_in;
  logic [HPW-1:0] shp_p;
  logic [HA-1:0]  shp_idx;
  logic [16:0]    nabs;
  logic signed [16:0] nx;
  logic [19:0]    lv;
  logic [24:0]    sh_val;
  logic [27:0]    nq_sum;

  logic                div_start;
  logic [DIV_NW-1:0]   div_num;
  logic [DIV_DW-1:0]   div_den;
  logic                div_done;
  logic [DIV_NW-1:0]   div_quo;

  kdv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign stat.silent     = (aenv < SILENCE_LEVEL) && (penv < SILENCE_LEVEL);
  assign stat.drive_zero = (drive == '0);
  assign stat.div_done   = div_done;

  assign prod = {32'b0, mul_a} * {34'b0, mul_b};

  assign nx   = {noise_q[15], noise_q};
  assign nabs = nx[16] ? 17'(-nx) : 17'(nx);
  assign gain = 20'(20'd65536 + {1'b0, drive, 2'b00});
  assign inc_w = {7'b0, prod[49:0]} << e_q[30:28];
  assign inc_s = inc_w >> INC_SH;
  assign sine_p = {{(SA + 1){1'b0}}, phase} * SPW'(SINE_TABLE_DEPTH);
  assign sine_idx = sine_p[PHASE_BITS +: SA];
  assign gm = {gain, 8'b0};
  assign sh_in = (cmd.op == OP_TG) ? gm[26:0] : t_q[26:0];
  assign shp_p = {{(HA + 1){1'b0}}, sh_in} * HPW'(SHAPER_TABLE_DEPTH);
  assign shp_idx = shp_p[27 +: HA];
  assign lv = prod[43:24];
  assign sh_val = big_q ? Q24_ONE : shp_q;
  // folded remainder is at most 32768 here, so one compare finishes the divide
  assign nq_sum = nq_q + 28'(t_q >= NOISE_DIV);

  assign div_start = (cmd.op == OP_SHD);
  assign div_num = {sh_val, 24'b0};
  assign div_den = tg_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_PENV: begin mul_a = 34'(penv);      mul_b = 32'(pcoef); end
      OP_ESW:  begin mul_a = 34'(sweep);     mul_b = 32'(penv); end
      OP_DIV3: begin mul_a = 34'(t_q[31:0]); mul_b = DIV3_RECIP; end
      OP_EXP, OP_EXPF: begin
        mul_a = 34'(e_q[27:0]);
        mul_b = 32'(p_q);
      end
      OP_INC:  begin mul_a = 34'(base_inc);  mul_b = 32'(p_q); end
      OP_CENV: begin mul_a = 34'(cenv);      mul_b = 32'(CLICK_DECAY); end
      OP_CLK:  begin mul_a = 34'(cenv);      mul_b = 32'(cmix); end
      OP_NENV: begin mul_a = 34'(nenv);      mul_b = 32'(ncoef); end
      OP_NM1:  begin mul_a = 34'(nabs);      mul_b = 32'(nmix); end
      OP_NM2:  begin mul_a = t_q[33:0];      mul_b = 32'(nenv); end
      OP_TGD:  begin mul_a = 34'(mag_q);     mul_b = 32'(gain); end
      OP_AENV: begin mul_a = 34'(aenv);      mul_b = 32'(bcoef); end
      OP_AMP:  begin mul_a = 34'(mag_q);     mul_b = 32'(aenv); end
      OP_LVL:  begin mul_a = 34'(mag_q);     mul_b = LEVEL_SCALE; end
      default: begin mul_a = '0;             mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_inc <= RST_BASE_INC;
      sweep    <= RST_SWEEP;
      pcoef    <= RST_PCOEF;
      bcoef    <= RST_BCOEF;
      ncoef    <= RST_NCOEF;
      nmix     <= RST_NMIX;
      drive    <= RST_DRIVE;
      cmix     <= RST_CMIX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_INC: base_inc <= cfg_data[19:0];
        REG_SWEEP:    sweep    <= cfg_data[9:0];
        REG_PCOEF:    pcoef    <= cfg_data;
        REG_BCOEF:    bcoef    <= cfg_data;
        REG_NCOEF:    ncoef    <= cfg_data;
        REG_NMIX:     nmix     <= cfg_data[16:0];
        REG_DRIVE:    drive    <= cfg_data[16:0];
        REG_CMIX:     cmix     <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      penv  <= ENV_FULL;
      aenv  <= ENV_FULL;
      nenv  <= ENV_FULL;
      cenv  <= ENV_FULL;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          if (kind) begin
            phase <= '0;
            penv  <= ENV_FULL;
            aenv  <= ENV_FULL;
            nenv  <= ENV_FULL;
            cenv  <= ENV_FULL;
          end
        end
        OP_PENV: penv  <= prod[47:24];
        OP_INC:  phase <= phase + inc_s[PHASE_BITS-1:0];
        OP_CENV: cenv  <= prod[47:24];
        OP_NENV: nenv  <= prod[47:24];
        OP_AENV: aenv  <= prod[47:24];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: noise_q <= noise_in;
      OP_SIL: begin
        audio_out <= '0;
        sounding  <= 1'b0;
      end
      OP_ESW:  t_q <= 42'(prod[33:2]);
      OP_DIV3: begin
        e_q <= prod[63:33];
        p_q <= EXP_COEF[5];
      end
      OP_EXP:  p_q <= 30'(EXP_COEF[cmd.idx] + prod[57:28]);
      OP_EXPF: p_q <= 30'(EXP_ONE + prod[57:28]);
      OP_INC:  sine_q <= SINE_ROM[sine_idx];
      OP_CENV: x_q <= 30'(sine_q);
      OP_CLK:  x_q <= x_q + $signed({4'b0, prod[40:15]});
      OP_NM1:  t_q <= 42'(prod[33:0]);
      OP_NM2: begin
        t_q  <= prod[57:16];
        nq_q <= '0;
      end
      // divide by 2^15-1: t = q*2^15 + r folds to q + r, q goes to the quotient
      OP_NDIV: begin
        t_q  <= 42'(t_q[41:15]) + 42'(t_q[14:0]);
        nq_q <= nq_q + 28'(t_q[41:15]);
      end
      OP_NADD: begin
        if (noise_q[15]) begin
          x_q <= x_q - $signed({2'b0, nq_sum});
        end else begin
          x_q <= x_q + $signed({2'b0, nq_sum});
        end
      end
      OP_MAG: begin
        neg_q <= x_q[29];
        mag_q <= x_q[29] ? 29'(-x_q) : 29'(x_q);
      end
      OP_TG: begin
        shp_q <= SHP_ROM[shp_idx];
        big_q <= gm[27];
      end
      OP_TGD: begin
        if (big_q) begin
          tg_q <= Q24_ONE;
        end else if (shp_q == '0) begin
          tg_q <= 25'd1;
        end else begin
          tg_q <= shp_q;
        end
        t_q <= 42'(prod[47:16]);
      end
      OP_SH: begin
        shp_q <= SHP_ROM[shp_idx];
        big_q <= |t_q[31:27];
      end
      OP_DRV:  mag_q <= div_quo[28:0];
      OP_AMP:  mag_q <= prod[52:24];
      OP_LVL: begin
        sounding <= 1'b1;
        if (neg_q) begin
          audio_out <= (lv > 20'd32768) ? 16'sh8000 : $signed(16'(20'd0 - lv));
        end else begin
          audio_out <= (lv > 20'd32767) ? 16'sh7FFF : $signed(lv[15:0]);
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/kdv_ctrl.sv
// Sequencer: walks the datapath through one sample and runs the handshakes.
module kdv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  kdv_pkg::kdv_stat_t  stat,
  output kdv_pkg::kdv_cmd_t   cmd
);
  import kdv_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CHECK = 5'd1;
  localparam logic [4:0] S_SIL   = 5'd2;
  localparam logic [4:0] S_PENV  = 5'd3;
  localparam logic [4:0] S_ESW   = 5'd4;
  localparam logic [4:0] S_DIV3  = 5'd5;
  localparam logic [4:0] S_EXP   = 5'd6;
  localparam logic [4:0] S_EXPF  = 5'd7;
  localparam logic [4:0] S_INC   = 5'd8;
  localparam logic [4:0] S_CENV  = 5'd9;
  localparam logic [4:0] S_CLK   = 5'd10;
  localparam logic [4:0] S_NENV  = 5'd11;
  localparam logic [4:0] S_NM1   = 5'd12;
  localparam logic [4:0] S_NM2   = 5'd13;
  localparam logic [4:0] S_NDIV  = 5'd14;
  localparam logic [4:0] S_NADD  = 5'd16;
  localparam logic [4:0] S_MAG   = 5'd17;
  localparam logic [4:0] S_TG    = 5'd18;
  localparam logic [4:0] S_TGD   = 5'd19;
  localparam logic [4:0] S_SH    = 5'd20;
  localparam logic [4:0] S_SHD   = 5'd21;
  localparam logic [4:0] S_DWAIT = 5'd22;
  localparam logic [4:0] S_DRV   = 5'd23;
  localparam logic [4:0] S_AENV  = 5'd24;
  localparam logic [4:0] S_AMP   = 5'd25;
  localparam logic [4:0] S_LVL   = 5'd26;
  localparam logic [4:0] S_OUT   = 5'd27;

  logic [4:0] state, state_next;
  logic [2:0] idx, idx_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd.op     = OP_NOP;
    cmd.idx    = idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: state_next = stat.silent ? S_SIL : S_PENV;
      S_SIL:   begin cmd.op = OP_SIL;  state_next = S_OUT; end
      S_PENV:  begin cmd.op = OP_PENV; state_next = S_ESW; end
      S_ESW:   begin cmd.op = OP_ESW;  state_next = S_DIV3; end
      S_DIV3: begin
        cmd.op     = OP_DIV3;
        idx_next   = 3'd4;
        state_next = S_EXP;
      end
      S_EXP: begin
        cmd.op   = OP_EXP;
        idx_next = idx - 1'b1;
        if (idx == 3'd0) begin
          state_next = S_EXPF;
        end
      end
      S_EXPF:  begin cmd.op = OP_EXPF; state_next = S_INC; end
      S_INC:   begin cmd.op = OP_INC;  state_next = S_CENV; end
      S_CENV:  begin cmd.op = OP_CENV; state_next = S_CLK; end
      S_CLK:   begin cmd.op = OP_CLK;  state_next = S_NENV; end
      S_NENV:  begin cmd.op = OP_NENV; state_next = S_NM1; end
      S_NM1:   begin cmd.op = OP_NM1;  state_next = S_NM2; end
      S_NM2: begin
        cmd.op     = OP_NM2;
        idx_next   = 3'd2;
        state_next = S_NDIV;
      end
      // three folds bring the noise product below 2^15 + 1
      S_NDIV: begin
        cmd.op   = OP_NDIV;
        idx_next = idx - 1'b1;
        if (idx == 3'd0) begin
          state_next = S_NADD;
        end
      end
      S_NADD:  begin cmd.op = OP_NADD; state_next = S_MAG; end
      S_MAG: begin
        cmd.op     = OP_MAG;
        state_next = stat.drive_zero ? S_AENV : S_TG;
      end
      S_TG:    begin cmd.op = OP_TG;   state_next = S_TGD; end
      S_TGD:   begin cmd.op = OP_TGD;  state_next = S_SH; end
      S_SH:    begin cmd.op = OP_SH;   state_next = S_SHD; end
      S_SHD:   begin cmd.op = OP_SHD;  state_next = S_DWAIT; end
      S_DWAIT: if (stat.div_done) state_next = S_DRV;
      S_DRV:   begin cmd.op = OP_DRV;  state_next = S_AENV; end
      S_AENV:  begin cmd.op = OP_AENV; state_next = S_AMP; end
      S_AMP:   begin cmd.op = OP_AMP;  state_next = S_LVL; end
      S_LVL:   begin cmd.op = OP_LVL;  state_next = S_OUT; end
      S_OUT:   if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

// File: rtl/core/kick_drum_voice_top.sv
// A silent tick reaches out_valid soonest, a sounding tick later and a tick with the
// soft clipper on last, since the pass of the restoring divider that normalizes the
// clipper output lies in its path.
// One transaction at a time; the next input is taken the cycle after the result
// is taken.
// Reset restores register defaults, zero phase and full-scale envelopes.
// Top level of the kick drum voice.
module kick_drum_voice_top #(
  parameter int          PHASE_BITS         = 24,
  parameter int          SINE_TABLE_DEPTH   = 1024,
  parameter int          SHAPER_TABLE_DEPTH = 1024,
  parameter logic [23:0] CLICK_DECAY        = 24'd16204694
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic signed [15:0] noise_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] audio_out,
  output logic               sounding
);
  import kdv_pkg::*;

  kdv_cmd_t  cmd;
  kdv_stat_t stat;

  kdv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kdv_dp #(
    .PHASE_BITS         (PHASE_BITS),
    .SINE_TABLE_DEPTH   (SINE_TABLE_DEPTH),
    .SHAPER_TABLE_DEPTH (SHAPER_TABLE_DEPTH),
    .CLICK_DECAY        (CLICK_DECAY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .kind      (kind),
    .noise_in  (noise_in),
    .audio_out (audio_out),
    .sounding  (sounding)
  );

endmodule

// File: rtl/core/kdv_checker.sv
// Port-level checks for the kick drum voice, bound to the top level.
module kdv_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] audio_out,
  input logic               sounding
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(audio_out) && $stable(sounding))
    else $error("result changed while stalled");

  // one transaction in flight: never ready for input while a result is pending
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // a result never appears the cycle after acceptance
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");

  // silent ticks carry zero audio
  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sounding |-> audio_out == 16'sd0)
    else $error("nonzero audio on silent tick");

endmodule

bind kick_drum_voice_top kdv_checker u_kdv_checker (.*);
